FILE: rtl/websocket_frame_decoder_defines.svh
// Assertion macros for the WebSocket frame decoder checker.
// Depends on signals named clk and rst in the scope of use.
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define WSFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("websocket frame decoder: assertion failed");

// Property checked on every clock edge, reset included.
`define WSFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("websocket frame decoder: assertion failed");

`endif

FILE: rtl/wsfd_pkg.sv
// Shared types and constants of the WebSocket frame decoder.
// No dependencies.
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_B0,
    PH_B1,
    PH_EXT,
    PH_KEY,
    PH_PAY
  } phase_t;

  typedef enum logic [1:0] {
    ST_FINAL    = 2'd0,
    ST_NONFINAL = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'h7e;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'h7f;
  localparam int unsigned FIN_BIT = 7;

  localparam logic [3:0] FIXED_HDR_BYTES = 4'd2;
  localparam logic [3:0] BASE_HDR_LEN    = 4'd6;
  localparam logic [3:0] EXT_LEN_16      = 4'd2;
  localparam logic [3:0] EXT_LEN_64      = 4'd8;
  localparam logic [3:0] LEN64_FIRST_USED = 4'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    status_t     frame_status;
    logic [3:0]  header_length;
    logic [31:0] content_length;
  } result_t;

endpackage

FILE: rtl/wsfd_in_reg.sv
// Input register of the WebSocket frame decoder: holds one received byte.
// Depends on wsfd_pkg.
module wsfd_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  wsfd_pkg::item_t s_item,
  input  logic           advance,
  output logic           held_valid,
  output wsfd_pkg::item_t held_item
);
  import wsfd_pkg::*;

  assign s_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      held_item <= s_item;
    end
  end
endmodule

FILE: rtl/wsfd_parser.sv
// Frame parser of the WebSocket frame decoder: header state machine,
// length and key registers, payload unmasking. Depends on wsfd_pkg.
module wsfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  wsfd_pkg::item_t   item,
  output logic             res_valid,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic        fin, fin_next;
  logic [3:0]  ext_len, ext_len_next;
  logic [31:0] total, total_next;
  logic [31:0] mask_key, mask_key_next;
  logic [31:0] idx, idx_next;

  logic [3:0]  hlen;
  logic [3:0]  hc_inc;
  logic [31:0] idx_inc;
  logic [6:0]  code;
  logic        last;
  logic        ext_done, key_done, pay_done, zero_len;
  logic [7:0]  key_byte;

  assign last     = item.buffer_end;
  assign code     = item.data_byte[6:0];
  assign hlen     = BASE_HDR_LEN + ext_len;
  assign hc_inc   = hdr_count + 4'd1;
  assign idx_inc  = idx + 32'd1;
  assign ext_done = hc_inc >= (FIXED_HDR_BYTES + ext_len);
  assign key_done = hc_inc >= hlen;
  assign pay_done = idx_inc == total;
  assign zero_len = total == 32'd0;

  always_comb begin
    case (idx[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Next phase.
  always_comb begin
    case (phase)
      PH_B0:  phase_next = last ? PH_B0 : PH_B1;
      PH_B1: begin
        if (last) begin
          phase_next = PH_B0;
        end else if (code == LEN_CODE_EXT16 || code == LEN_CODE_EXT64) begin
          phase_next = PH_EXT;
        end else begin
          phase_next = PH_KEY;
        end
      end
      PH_EXT: phase_next = last ? PH_B0 : (ext_done ? PH_KEY : PH_EXT);
      PH_KEY: begin
        if (last || (key_done && zero_len)) begin
          phase_next = PH_B0;
        end else begin
          phase_next = key_done ? PH_PAY : PH_KEY;
        end
      end
      PH_PAY:  phase_next = (pay_done || last) ? PH_B0 : PH_PAY;
      default: phase_next = PH_B0;
    endcase
  end

  // Header and payload registers.
  always_comb begin
    hdr_count_next = hdr_count;
    fin_next       = fin;
    ext_len_next   = ext_len;
    total_next     = total;
    mask_key_next  = mask_key;
    idx_next       = idx;
    case (phase)
      PH_B0: begin
        fin_next       = item.data_byte[FIN_BIT];
        hdr_count_next = 4'd1;
        ext_len_next   = 4'd0;
        total_next     = 32'd0;
        mask_key_next  = 32'd0;
        idx_next       = 32'd0;
      end
      PH_B1: begin
        if (code == LEN_CODE_EXT16) begin
          ext_len_next = EXT_LEN_16;
          total_next   = 32'd0;
        end else if (code == LEN_CODE_EXT64) begin
          ext_len_next = EXT_LEN_64;
          total_next   = 32'd0;
        end else begin
          ext_len_next = 4'd0;
          total_next   = {25'd0, code};
        end
        hdr_count_next = FIXED_HDR_BYTES;
      end
      PH_EXT: begin
        // Only the low four bytes of a 64-bit length are kept.
        if (ext_len != EXT_LEN_64 || hdr_count >= LEN64_FIRST_USED) begin
          total_next = {total[23:0], item.data_byte};
        end
        hdr_count_next = hc_inc;
      end
      PH_KEY: begin
        mask_key_next  = {mask_key[23:0], item.data_byte};
        hdr_count_next = hc_inc;
        if (key_done) begin
          idx_next = 32'd0;
        end
      end
      PH_PAY:  idx_next = idx_inc;
      default: ;
    endcase
    if (phase_next == PH_B0) begin
      hdr_count_next = 4'd0;
      fin_next       = 1'b0;
      ext_len_next   = 4'd0;
      total_next     = 32'd0;
      mask_key_next  = 32'd0;
      idx_next       = 32'd0;
    end
  end

  // Result of the current byte.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      PH_PAY: begin
        res_valid        = 1'b1;
        res.byte_valid   = 1'b1;
        res.payload_byte = item.data_byte ^ key_byte;
        if (pay_done) begin
          res.frame_end      = 1'b1;
          res.frame_status   = fin ? ST_FINAL : ST_NONFINAL;
          res.header_length  = hlen;
          res.content_length = total;
        end else if (last) begin
          res.frame_end      = 1'b1;
          res.frame_status   = ST_ERROR;
          res.header_length  = hlen;
          res.content_length = total;
        end
      end
      PH_KEY: begin
        if (key_done && zero_len) begin
          res_valid         = 1'b1;
          res.frame_end     = 1'b1;
          res.frame_status  = ST_ERROR;
          res.header_length = hlen;
        end else if (last) begin
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = ST_ERROR;
        end
      end
      default: begin
        if (last) begin
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = ST_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_B0;
      hdr_count <= 4'd0;
      fin       <= 1'b0;
      ext_len   <= 4'd0;
      total     <= 32'd0;
      mask_key  <= 32'd0;
      idx       <= 32'd0;
    end else if (advance) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      fin       <= fin_next;
      ext_len   <= ext_len_next;
      total     <= total_next;
      mask_key  <= mask_key_next;
      idx       <= idx_next;
    end
  end
endmodule

FILE: rtl/wsfd_out_reg.sv
// Result register of the WebSocket frame decoder.
// Depends on wsfd_pkg.
module wsfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             res_valid,
  input  wsfd_pkg::result_t res,
  input  logic             m_ready,
  output logic             m_valid,
  output wsfd_pkg::result_t m_res
);
  import wsfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= res_valid;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_res <= res;
    end
  end
endmodule

FILE: rtl/websocket_frame_decoder.sv
// WebSocket frame decoder: byte-stream deframer with payload unmasking.
// Uses wsfd_pkg, wsfd_in_reg, wsfd_parser and wsfd_out_reg.
//
// Usage. Received bytes enter on the slave stream, one byte per request, with
// s_tlast set on the last byte of a receive buffer. Each byte goes into an
// input register; from there the parser takes it, updates the
// header state and, when the byte produces a result, loads the result
// register that drives the master stream. Header bytes produce no result,
// except when they close the frame with an error. Payload bytes come out
// unmasked with byte_valid set; the request that closes a frame has m_tlast
// set and carries status, header length and content length. A frame with
// error status is to be discarded by the consumer, including payload bytes
// already delivered. After every closing result the parser starts afresh.
//
// A byte passes the input register and then the result register on its way
// to the master side. Throughput is one byte per cycle while m_tready stays
// high (the 32-bit payload counter compare is the longest path). Synchronous
// reset empties both registers and returns the parser to the first header
// byte. When the receiver holds m_tready low, the result register keeps its
// request and one further byte may wait in the input register; s_tready then
// drops until the result is taken.
module websocket_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  // Slave stream: tdata = data_byte[7:0]; tlast = buffer_end.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // Master stream: tdata = payload_byte[7:0], header_length[11:8],
  // content_length[43:12], zero fill[47:44]; tlast = frame_end.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  // tuser = byte_valid[0], frame_status[2:1].
  output logic [2:0]  m_tuser
);
  import wsfd_pkg::*;

  item_t   s_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_item.data_byte  = s_tdata;
  assign s_item.buffer_end = s_tlast;

  // A held byte is parsed whenever the result register is free or emptying.
  assign advance = held_valid && (!m_tvalid || m_tready);

  wsfd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_item    (s_item),
    .advance   (advance),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  wsfd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (held_item),
    .res_valid(res_valid),
    .res      (res)
  );

  wsfd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .res_valid(res_valid),
    .res      (res),
    .m_ready  (m_tready),
    .m_valid  (m_tvalid),
    .m_res    (m_res)
  );

  assign m_tdata = {4'd0, m_res.content_length, m_res.header_length, m_res.payload_byte};
  assign m_tlast = m_res.frame_end;
  assign m_tuser = {m_res.frame_status, m_res.byte_valid};
endmodule

FILE: rtl/wsfd_checker.sv
// Port-level checks of the WebSocket frame decoder, bound to the top level.
// Depends on wsfd_pkg and websocket_frame_decoder_defines.svh.
`include "websocket_frame_decoder_defines.svh"

module wsfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast,
  input logic [2:0]  m_tuser
);
  import wsfd_pkg::*;

  logic       res_stalled;
  logic [1:0] res_status;
  logic       hlen_ok;

  assign res_stalled = m_tvalid && !m_tready;
  assign res_status  = m_tuser[2:1];
  assign hlen_ok     = (m_tdata[11:8] == BASE_HDR_LEN) ||
                       (m_tdata[11:8] == BASE_HDR_LEN + EXT_LEN_16) ||
                       (m_tdata[11:8] == BASE_HDR_LEN + EXT_LEN_64);

  // A stalled result holds still.
  `WSFD_ASSERT(a_stall_hold, res_stalled |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

  // Reset leaves no result pending.
  `WSFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)

  // A result without a payload byte only ever closes a frame, with error status.
  `WSFD_ASSERT(a_nobyte_closes, m_tvalid && !m_tuser[0] |-> m_tlast && res_status == ST_ERROR)

  // With the result register empty the input side is always open.
  `WSFD_ASSERT(a_empty_ready, !m_tvalid |-> s_tready)

  // A good frame ends on a payload byte with a legal header length.
  `WSFD_ASSERT(a_good_end, m_tvalid && m_tlast && res_status != ST_ERROR |-> m_tuser[0] && hlen_ok)
endmodule

bind websocket_frame_decoder wsfd_checker u_checker (.*);

FILE: bench/tb_websocket_frame_decoder.sv
`timescale 1ns / 1ps
// Self-checking bench for the WebSocket frame decoder: byte streams, predicted results.
// Depends on wsfd_pkg and websocket_frame_decoder; needs no other files.
module tb_websocket_frame_decoder;
  import wsfd_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 650;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_byte_t;

  // One result of the deframer, in the field order of the block's outputs.
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        closes;
    status_t     status;
    logic [3:0]  hdr_len;
    logic [31:0] body_len;
  } frame_res_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;

  rx_byte_t   rx_q[$];         // bytes still to be offered
  frame_res_t deframed_q[$];   // results owed by the block, oldest first

  // Parser state of the prediction.
  phase_t      ph;
  logic [3:0]  hcount;
  logic        fin;
  logic [3:0]  extra;
  logic [31:0] total;
  logic [31:0] key;
  logic [31:0] idx;

  int n_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;
  int n_bad = 0;
  int n_final = 0;
  int n_nonfinal = 0;
  int n_error = 0;
  int n_payload = 0;
  logic calm;

  // A stretch of the run in which neither side idles.
  assign calm = (n_taken >= 400) && (n_taken < 520);

  websocket_frame_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_parser();
    ph = PH_B0;
    hcount = '0;
    fin = 1'b0;
    extra = '0;
    total = '0;
    key = '0;
    idx = '0;
  endfunction

  function automatic frame_res_t closing(input status_t st, input logic [3:0] hl,
                                         input logic [31:0] cl);
    frame_res_t r;
    r = '0;
    r.closes = 1'b1;
    r.status = st;
    r.hdr_len = hl;
    r.body_len = cl;
    return r;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_step(input logic [7:0] b, input logic last,
                                      output frame_res_t r);
    logic [3:0]  hlen;
    logic [6:0]  code;
    logic [31:0] shifted;
    hlen = BASE_HDR_LEN + extra;
    r = '0;
    case (ph)
      PH_B1: begin
        code = b[6:0];
        if (code == LEN_CODE_EXT16) begin
          extra = EXT_LEN_16;
          total = '0;
          ph = PH_EXT;
        end else if (code == LEN_CODE_EXT64) begin
          extra = EXT_LEN_64;
          total = '0;
          ph = PH_EXT;
        end else begin
          extra = '0;
          total = {25'd0, code};
          ph = PH_KEY;
        end
        hcount = FIXED_HDR_BYTES;
      end
      PH_EXT: begin
        // Of the eight length bytes after code 0x7f, only the last four count.
        if (extra != EXT_LEN_64 || hcount >= LEN64_FIRST_USED) begin
          total = {total[23:0], b};
        end
        hcount = hcount + 4'd1;
        if (hcount >= FIXED_HDR_BYTES + extra) begin
          ph = PH_KEY;
        end
      end
      PH_KEY: begin
        key = {key[23:0], b};
        hcount = hcount + 4'd1;
        if (hcount >= hlen) begin
          // A complete header announcing no payload is an error.
          if (total == '0) begin
            r = closing(ST_ERROR, hlen, '0);
            clear_parser();
            return 1'b1;
          end
          idx = '0;
          ph = PH_PAY;
        end
      end
      PH_PAY: begin
        shifted = key >> (24 - 8 * idx[1:0]);
        idx = idx + 32'd1;
        if (idx == total) begin
          r = closing(fin ? ST_FINAL : ST_NONFINAL, hlen, total);
        end else if (last) begin
          // Buffer ran out inside the payload: byte still delivered, frame is bad.
          r = closing(ST_ERROR, hlen, total);
        end
        r.valid = 1'b1;
        r.data = b ^ shifted[7:0];
        if (r.closes) begin
          clear_parser();
        end
        return 1'b1;
      end
      default: begin
        clear_parser();
        fin = b[FIN_BIT];
        hcount = 4'd1;
        ph = PH_B1;
      end
    endcase
    // Buffer ended inside the header.
    if (last) begin
      r = closing(ST_ERROR, '0, '0);
      clear_parser();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last);
    rx_byte_t x;
    x.data = data;
    x.last = last;
    rx_q.insert(rx_q.size(), x);
  endtask

  // Queues one frame with random key, payload and ignored bits. A negative cut sends
  // the whole frame with tail_last on its final byte; otherwise the buffer ends after
  // cut bytes at most. Whole frames are only asked for with small lengths.
  task automatic push_frame(input logic f, input len_kind_t kind, input logic [31:0] len,
                            input int cut, input logic tail_last);
    logic [7:0] hdr[$];
    logic [7:0] rnd;
    longint     full;
    longint     stop;
    longint     i;
    rnd = 8'($urandom);
    hdr.insert(hdr.size(), {f, rnd[6:0]});
    rnd = 8'($urandom);
    case (kind)
      LEN_SHORT: hdr.insert(hdr.size(), {rnd[7], len[6:0]});
      LEN_EXT16: begin
        hdr.insert(hdr.size(), {rnd[7], LEN_CODE_EXT16});
        hdr.insert(hdr.size(), len[15:8]);
        hdr.insert(hdr.size(), len[7:0]);
      end
      default: begin
        hdr.insert(hdr.size(), {rnd[7], LEN_CODE_EXT64});
        repeat (4) hdr.insert(hdr.size(), 8'($urandom));
        hdr.insert(hdr.size(), len[31:24]);
        hdr.insert(hdr.size(), len[23:16]);
        hdr.insert(hdr.size(), len[15:8]);
        hdr.insert(hdr.size(), len[7:0]);
      end
    endcase
    repeat (4) hdr.insert(hdr.size(), 8'($urandom));
    full = hdr.size() + longint'(len);
    stop = (cut < 0 || cut > full) ? full : cut;
    for (i = 0; i < stop; i++) begin
      push_byte(i < hdr.size() ? hdr[i] : 8'($urandom),
                (i == stop - 1) ? ((cut < 0) ? tail_last : 1'b1) : 1'b0);
    end
  endtask

  // Sender: offers queued bytes and feeds every accepted byte to the prediction.
  always @(posedge clk) begin : drive_proc
    frame_res_t res;
    bit         offer;
    rx_byte_t   nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      clear_parser();
    end else begin
      if (s_tvalid && s_tready) begin
        if (deframe_step(s_tdata, s_tlast, res)) begin
          deframed_q.insert(deframed_q.size(), res);
        end
        n_taken <= n_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        // Keep offering throughout the hold-off so that the block backs up.
        offer = (rx_q.size() != 0) &&
                (calm || hold_left != 0 || $urandom_range(0, 99) >= 35);
        if (offer) begin
          nxt = rx_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
          s_tlast <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted request against the oldest owed result.
  always @(posedge clk) begin : sink_proc
    frame_res_t got;
    frame_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.valid = m_tuser[0];
        got.status = status_t'(m_tuser[2:1]);
        got.data = m_tdata[7:0];
        got.hdr_len = m_tdata[11:8];
        got.body_len = m_tdata[43:12];
        got.closes = m_tlast;
        if (got.valid) n_payload++;
        if (got.closes) begin
          if (got.status == ST_FINAL) n_final++;
          else if (got.status == ST_NONFINAL) n_nonfinal++;
          else n_error++;
        end
        if (deframed_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: unexpected result v=%0b byte=%h end=%0b st=%0d hl=%0d cl=%h",
                     $realtime, got.valid, got.data, got.closes, got.status,
                     got.hdr_len, got.body_len);
          end
        end else begin
          want = deframed_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: result differs, expected v=%0b byte=%h end=%0b st=%0d hl=%0d cl=%h",
                       $realtime, want.valid, want.data, want.closes, want.status,
                       want.hdr_len, want.body_len);
              $display("%0t:                    got v=%0b byte=%h end=%0b st=%0d hl=%0d cl=%h",
                       $realtime, got.valid, got.data, got.closes, got.status,
                       got.hdr_len, got.body_len);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!hold_done && n_taken >= 250) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || $urandom_range(0, 99) >= 35;
      end
    end
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk) begin : watchdog_proc
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $realtime, stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus_proc
    int          pick;
    int          n;
    int          burst;
    len_kind_t   kind;
    logic        f;
    logic [31:0] len;
    int          leftover;

    // Directed opening: a buffer that ends on the first header byte, a zero length
    // via the 16-bit form, a 64-bit form with ignored length bytes cut inside the
    // payload, and a non-final fragment whose last byte also ends the buffer.
    push_byte(8'h81, 1'b1);
    push_frame(1'b1, LEN_EXT16, 32'd0, -1, 1'b0);
    push_frame(1'b1, LEN_EXT64, 32'd2, 15, 1'b0);
    push_frame(1'b0, LEN_SHORT, 32'd1, -1, 1'b1);

    // Mostly well-formed frames with random content, plus truncations, zero
    // lengths and short bursts of garbage ending a buffer.
    n = rx_q.size();
    while (rx_q.size() < n + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      kind = len_kind_t'($urandom_range(0, 2));
      f = 1'($urandom);
      if (pick < 68) begin
        case (kind)
          LEN_SHORT: len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 125)
                                                       : $urandom_range(1, 12);
          LEN_EXT16: len = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 300)
                                                        : $urandom_range(1, 24);
          default:   len = $urandom_range(1, 16);
        endcase
        push_frame(f, kind, len, -1, $urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        case (kind)
          LEN_SHORT: len = $urandom_range(1, 125);
          LEN_EXT16: len = {16'd0, 16'($urandom)};
          default:   len = $urandom;
        endcase
        push_frame(f, kind, len, $urandom_range(1, 20), 1'b0);
      end else if (pick < 90) begin
        push_frame(f, kind, 32'd0, -1, 1'($urandom));
      end else begin
        burst = $urandom_range(1, 3);
        for (int i = 0; i < burst; i++) begin
          push_byte(8'($urandom), i == burst - 1);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (rx_q.size() != 0 || s_tvalid) @(negedge clk);
    while (deframed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    leftover = deframed_q.size();
    $display("Run covered %0d input bytes, %0d unmasked payload bytes delivered.",
             n_taken, n_payload);
    $display("Frames closed: %0d final, %0d non-final, %0d in error; %0d mismatches.",
             n_final, n_nonfinal, n_error, n_bad + leftover);
    if (n_bad == 0 && leftover == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_in_reg.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_reg.sv
rtl/websocket_frame_decoder.sv
rtl/wsfd_checker.sv
bench/tb_websocket_frame_decoder.sv
